// ===== src/pfd_pkg.sv =====
// ----------------------------------------------------------------------------
// pfd_pkg
// Shared types and constants for the PPM frame decoder.
// ----------------------------------------------------------------------------
package pfd_pkg;

    localparam int CHANNELS = 8;
    localparam int CNT_W    = 4;
    localparam int TICK_W   = 16;
    localparam int IDX_W    = 4;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 4;

    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [TICK_W-1:0] tick_t;

    localparam cnt_t CHAN_CNT  = cnt_t'(CHANNELS);
    localparam cnt_t WAIT_SYNC = cnt_t'(CHANNELS + 2);

    localparam tick_t MIN_PULSE_RST = tick_t'(1500);
    localparam tick_t MAX_PULSE_RST = tick_t'(4500);
    localparam tick_t SYNC_GAP_RST  = tick_t'(10000);
    localparam logic  TICK_SHIFT_RST = 1'b1;

    typedef enum logic [1:0] {
        FAIL_OVERFLOW = 2'd0,
        FAIL_INVALID  = 2'd1,
        FAIL_FEW_CHAN = 2'd2
    } fail_code_t;

    typedef enum logic [1:0] {
        REG_MIN_PULSE  = 2'd0,
        REG_MAX_PULSE  = 2'd1,
        REG_SYNC_GAP   = 2'd2,
        REG_TICK_SHIFT = 2'd3
    } reg_idx_t;

    typedef enum logic {
        FUNC_INTERVAL = 1'b0,
        FUNC_OVERFLOW = 1'b1
    } func_t;

    typedef struct packed {
        tick_t min_pulse_ticks;
        tick_t max_pulse_ticks;
        tick_t sync_gap_ticks;
        logic  tick_shift;
    } cfg_t;

    typedef struct packed {
        func_t func;
        tick_t interval_ticks;
    } item_t;

    typedef struct packed {
        logic             write_valid;
        logic [IDX_W-1:0] channel_index;
        tick_t            pulse_us;
        logic             frame_complete;
        logic             fail_valid;
        fail_code_t       fail_code;
    } result_t;

endpackage

// ===== src/ppm_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// ppm_frame_decoder
// Decodes RC pulse-position frames from measured edge intervals.
// ----------------------------------------------------------------------------
//  port group   dir  carries
//  s_axis_*     in   interval word (tdata) or timer overflow (tuser)
//  m_axis_*     out  channel write / failure report, tlast on frame complete
//  APB          in   pulse limits, sync gap, tick shift
//
//  One word per cycle sustained while m_axis_tready stays high; a result is
//  offered from the result register, which the input register feeds in one pass.
//  While a result waits on m_axis_tready, the input register takes at most
//  one more word and then holds s_axis_tready low.
//  Synchronous active-low reset; after reset the decoder waits for sync.
// ----------------------------------------------------------------------------
module ppm_frame_decoder (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [15:0] interval_ticks
    input  logic [pfd_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // [0] func
    input  logic                          s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [3:0] channel_index, [19:4] pulse_us, [23:20] zero
    output logic [pfd_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // [0] write_valid, [1] fail_valid, [3:2] fail_code
    output logic [pfd_pkg::M_TUSER_W-1:0] m_axis_tuser,
    output logic                          m_axis_tlast,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pfd_pkg::APB_AW-1:0]    paddr,
    input  logic [pfd_pkg::APB_DW-1:0]    pwdata,
    output logic [pfd_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);
    import pfd_pkg::*;

    cfg_t    cfg;
    item_t   item;
    logic    item_valid;
    logic    advance;
    result_t result;

    pfd_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pfd_in_stage u_in (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .advance       (advance),
        .item_valid    (item_valid),
        .item          (item)
    );

    pfd_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .advance    (advance),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .result     (result)
    );

    assign m_axis_tdata = {4'b0000, result.pulse_us, result.channel_index};
    assign m_axis_tuser = {result.fail_code, result.fail_valid, result.write_valid};
    assign m_axis_tlast = result.frame_complete;

endmodule

// ===== src/pfd_apb_regs.sv =====
// ----------------------------------------------------------------------------
// pfd_apb_regs
// APB register file holding the pulse limits, sync gap and tick shift.
// ----------------------------------------------------------------------------
module pfd_apb_regs (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [pfd_pkg::APB_AW-1:0] paddr,
    input  logic [pfd_pkg::APB_DW-1:0] pwdata,
    output logic [pfd_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    output pfd_pkg::cfg_t              cfg
);
    import pfd_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t sel;
    logic     wr_en;

    assign pready = 1'b1;
    assign sel    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_pulse_ticks <= MIN_PULSE_RST;
            cfg_reg.max_pulse_ticks <= MAX_PULSE_RST;
            cfg_reg.sync_gap_ticks  <= SYNC_GAP_RST;
            cfg_reg.tick_shift      <= TICK_SHIFT_RST;
        end else if (wr_en) begin
            unique case (sel)
                REG_MIN_PULSE:  cfg_reg.min_pulse_ticks <= pwdata[TICK_W-1:0];
                REG_MAX_PULSE:  cfg_reg.max_pulse_ticks <= pwdata[TICK_W-1:0];
                REG_SYNC_GAP:   cfg_reg.sync_gap_ticks  <= pwdata[TICK_W-1:0];
                REG_TICK_SHIFT: cfg_reg.tick_shift      <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (sel)
            REG_MIN_PULSE:  prdata = APB_DW'(cfg_reg.min_pulse_ticks);
            REG_MAX_PULSE:  prdata = APB_DW'(cfg_reg.max_pulse_ticks);
            REG_SYNC_GAP:   prdata = APB_DW'(cfg_reg.sync_gap_ticks);
            REG_TICK_SHIFT: prdata = APB_DW'(cfg_reg.tick_shift);
            default:        prdata = '0;
        endcase
    end

endmodule

// ===== src/pfd_in_stage.sv =====
// ----------------------------------------------------------------------------
// pfd_in_stage
// Input register for interval and overflow words.
// ----------------------------------------------------------------------------
module pfd_in_stage (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [pfd_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input  logic                       s_axis_tuser,
    input  logic                       advance,
    output logic                       item_valid,
    output pfd_pkg::item_t             item
);
    import pfd_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign s_axis_tready = !valid_reg || advance;
    assign item_valid    = valid_reg;
    assign item          = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_axis_tready) begin
            valid_next = s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            item_reg.func           <= func_t'(s_axis_tuser);
            item_reg.interval_ticks <= s_axis_tdata[TICK_W-1:0];
        end
    end

endmodule

// ===== src/pfd_core.sv =====
// ----------------------------------------------------------------------------
// pfd_core
// Channel counter, range checks and result register.
// ----------------------------------------------------------------------------
module pfd_core (
    input  logic           aclk,
    input  logic           aresetn,
    input  pfd_pkg::cfg_t  cfg,
    input  logic           item_valid,
    input  pfd_pkg::item_t item,
    output logic           advance,
    output logic           out_valid,
    input  logic           out_ready,
    output pfd_pkg::result_t result
);
    import pfd_pkg::*;

    cnt_t    cnt_reg;
    cnt_t    cnt_next;
    cnt_t    cnt_inc;
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t res_reg;
    result_t res_next;
    logic    in_range;

    assign advance   = item_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign result    = res_reg;
    assign cnt_inc   = cnt_reg + cnt_t'(1);
    assign in_range  = (item.interval_ticks >= cfg.min_pulse_ticks) &&
                       (item.interval_ticks <= cfg.max_pulse_ticks);

    always_comb begin
        cnt_next = cnt_reg;
        res_next = '0;
        if (item.func == FUNC_OVERFLOW) begin
            res_next.fail_valid = 1'b1;
            res_next.fail_code  = FAIL_OVERFLOW;
            cnt_next            = WAIT_SYNC;
        end else if (item.interval_ticks >= cfg.sync_gap_ticks) begin
            if (cnt_reg < CHAN_CNT) begin
                res_next.fail_valid = 1'b1;
                res_next.fail_code  = FAIL_FEW_CHAN;
            end
            cnt_next = '0;
        end else if (cnt_reg < CHAN_CNT) begin
            if (in_range) begin
                res_next.write_valid    = 1'b1;
                res_next.channel_index  = IDX_W'(cnt_reg);
                res_next.pulse_us       = cfg.tick_shift ? (item.interval_ticks >> 1)
                                                         : item.interval_ticks;
                res_next.frame_complete = (cnt_inc == CHAN_CNT);
                cnt_next                = cnt_inc;
            end else begin
                res_next.fail_valid = 1'b1;
                res_next.fail_code  = FAIL_INVALID;
                cnt_next            = WAIT_SYNC;
            end
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg       <= WAIT_SYNC;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (advance) begin
                cnt_reg <= cnt_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

endmodule
